[sv/pcd_pkg.sv]
// Shared types and constants of the prefix-code tree pixel decoder.
package pcd_pkg;

  localparam int OP_W       = 2;
  localparam int CODE_W     = 16;
  localparam int CODE_IDX_W = 4;
  localparam int LEN_W      = 5;
  localparam int SYM_W      = 8;
  localparam int GREY_W     = 8;
  localparam int PIX_W      = 24;
  localparam int POS_W      = 12;
  localparam int ERR_W      = 2;
  localparam int MODE_W     = 2;
  localparam int WIDTH_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [POS_W-1:0]   ROW_MAX         = 12'd4095;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX       = 13'd4096;
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd640;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_CODE    = 2'd0,
    OP_GREY_WRITE  = 2'd1,
    OP_COLOR_WRITE = 2'd2,
    OP_CODE_BIT    = 2'd3
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_TREE_FULL = 2'd1,
    ERR_NO_CHILD  = 2'd2
  } err_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_GREY    = 2'd0,
    MODE_IMPOSED = 2'd1,
    MODE_COLOR   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 1'b0,
    CFG_COLOR_MODE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  code_symbol;
    logic [SYM_W-1:0]  palette_index;
    logic [PIX_W-1:0]  palette_value;
    logic              code_bit;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [SYM_W-1:0] color_index;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [ERR_W-1:0] error_code;
  } result_t;

endpackage

[sv/pcd_item_if.sv]
// Input channel of the decoder: valid, ready and one input item.
interface pcd_item_if;
  import pcd_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pcd_result_if.sv]
// Output channel of the decoder: valid, ready and one result item.
interface pcd_result_if;
  import pcd_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pcd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/prefix_code_tree_pixel_decoder_core.sv]
// Top level of the prefix-code tree pixel decoder with node and palette memories.
// A code bit that lands on an internal node reads that node and returns to idle; one that
// lands on a leaf also reads the palette, and its pixel is in the output register once the
// output is free; a missing child gives an error result. A palette write reads, then writes
// the entry. An insert reads or allocates a node per codeword bit, plus a symbol write if the last existed.
// Reset is asynchronous: root empty, one node in use, walk at the root, column and row 0.
// Memories are not cleared; nodes are cleared as they are allocated.
module prefix_code_tree_pixel_decoder_core #(
  parameter int TREE_NODES    = 512,
  parameter int MAX_CODE_BITS = 16,
  parameter int PALETTE_SIZE  = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  pcd_item_if.sink                         item_i,
  pcd_result_if.source                     result_o
);
  import pcd_pkg::*;

  localparam int NW = $clog2(TREE_NODES);
  localparam int UW = $clog2(TREE_NODES + 1);
  localparam int PW = $clog2(PALETTE_SIZE);
  localparam int EW = 2 * NW + SYM_W;
  localparam int PAL_W = GREY_W + PIX_W;

  typedef struct packed {
    logic [NW-1:0]    left;
    logic [NW-1:0]    right;
    logic [SYM_W-1:0] symbol;
  } node_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_DEC_READ = 10'b00_0000_0010,
    ST_DEC_PAL  = 10'b00_0000_0100,
    ST_DEC_ERR  = 10'b00_0000_1000,
    ST_INS_WALK = 10'b00_0001_0000,
    ST_INS_READ = 10'b00_0010_0000,
    ST_INS_NEW  = 10'b00_0100_0000,
    ST_INS_SYM  = 10'b00_1000_0000,
    ST_PAL_READ = 10'b01_0000_0000,
    ST_PAL_IDLE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [WIDTH_W-1:0] image_width_q;
  logic [MODE_W-1:0]  color_mode_q;

  logic [NW-1:0]      root_l_q, root_l_d, root_r_q, root_r_d;
  logic [NW-1:0]      cur_q, cur_d;
  node_t              cache_q, cache_d;
  logic [UW-1:0]      nodes_used_q, nodes_used_d;
  logic [POS_W-1:0]   col_q, col_d, row_q, row_d;

  logic [NW-1:0]      child_q, child_d;
  logic [NW-1:0]      ins_node_q, ins_node_d;
  node_t              ent_q, ent_d;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [CODE_W-1:0]  val_q, val_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic               pal_grey_q, pal_grey_d;
  logic [PW-1:0]      pal_idx_q, pal_idx_d;
  logic [PIX_W-1:0]   pal_val_q, pal_val_d;

  logic               res_valid_q;
  result_t            res_q, res_d;
  logic               res_set;
  logic               out_free;
  logic               adv;

  logic               nm_we, nm_re;
  logic [NW-1:0]      nm_waddr, nm_raddr;
  logic [EW-1:0]      nm_wdata, nm_rdata;
  node_t              node_rd;
  logic               pm_we, pm_re;
  logic [PW-1:0]      pm_waddr, pm_raddr;
  logic [PAL_W-1:0]   pm_wdata, pm_rdata;

  node_t              cur_ent, upd_ent;
  logic [NW-1:0]      bit_child, slot;
  logic [LEN_W-1:0]   len_eff;
  logic               ins_bit;
  logic [WIDTH_W-1:0] w_eff, col_inc;
  logic [PIX_W-1:0]   pix_val;

  pcd_ram #(.WIDTH(EW), .DEPTH(TREE_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .re_i    (nm_re),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  pcd_ram #(.WIDTH(PAL_W), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .re_i    (pm_re),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  assign node_rd  = node_t'(nm_rdata);
  assign out_free = !res_valid_q || result_o.ready;

  assign item_i.ready   = (state_q == ST_IDLE);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  always_comb begin
    if (cur_q == '0) begin
      cur_ent = '{left: root_l_q, right: root_r_q, symbol: '0};
    end else begin
      cur_ent = cache_q;
    end
    bit_child = item_i.data.code_bit ? cur_ent.right : cur_ent.left;
    if (32'(item_i.data.code_length) > MAX_CODE_BITS) begin
      len_eff = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_eff = item_i.data.code_length;
    end
    ins_bit = (pos_q < LEN_W'(CODE_W)) ? val_q[pos_q[CODE_IDX_W-1:0]] : 1'b0;
    slot    = ins_bit ? ent_q.right : ent_q.left;
    upd_ent = ent_q;
    if (ins_bit) begin
      upd_ent.right = nodes_used_q[NW-1:0];
    end else begin
      upd_ent.left = nodes_used_q[NW-1:0];
    end
  end

  always_comb begin
    pix_val = '0;
    if (32'(sym_q) < PALETTE_SIZE) begin
      case (color_mode_q)
        MODE_GREY, MODE_IMPOSED: pix_val = PIX_W'(pm_rdata[PAL_W-1:PIX_W]);
        MODE_COLOR:              pix_val = pm_rdata[PIX_W-1:0];
        default:                 pix_val = '0;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    root_l_d     = root_l_q;
    root_r_d     = root_r_q;
    cur_d        = cur_q;
    cache_d      = cache_q;
    nodes_used_d = nodes_used_q;
    child_d      = child_q;
    ins_node_d   = ins_node_q;
    ent_d        = ent_q;
    pos_d        = pos_q;
    val_d        = val_q;
    sym_d        = sym_q;
    pal_grey_d   = pal_grey_q;
    pal_idx_d    = pal_idx_q;
    pal_val_d    = pal_val_q;
    nm_we        = 1'b0;
    nm_waddr     = '0;
    nm_wdata     = '0;
    nm_re        = 1'b0;
    nm_raddr     = '0;
    pm_we        = 1'b0;
    pm_waddr     = '0;
    pm_wdata     = '0;
    pm_re        = 1'b0;
    pm_raddr     = '0;
    res_set      = 1'b0;
    res_d        = '0;
    adv          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          unique case (item_i.data.op)
            OP_ADD_CODE: begin
              if (item_i.data.code_length != '0) begin
                ins_node_d = '0;
                ent_d      = '{left: root_l_q, right: root_r_q, symbol: '0};
                pos_d      = len_eff - 1'b1;
                val_d      = item_i.data.code_value;
                sym_d      = item_i.data.code_symbol;
                state_d    = ST_INS_WALK;
              end
            end
            OP_GREY_WRITE, OP_COLOR_WRITE: begin
              if (32'(item_i.data.palette_index) < PALETTE_SIZE) begin
                pm_re      = 1'b1;
                pm_raddr   = PW'(item_i.data.palette_index);
                pal_idx_d  = PW'(item_i.data.palette_index);
                pal_val_d  = item_i.data.palette_value;
                pal_grey_d = (item_i.data.op == OP_GREY_WRITE);
                state_d    = ST_PAL_READ;
              end
            end
            OP_CODE_BIT: begin
              child_d = bit_child;
              if (bit_child == '0) begin
                cur_d   = '0;
                state_d = ST_DEC_ERR;
              end else begin
                nm_re    = 1'b1;
                nm_raddr = bit_child;
                state_d  = ST_DEC_READ;
              end
            end
          endcase
        end
      end
      ST_DEC_READ: begin
        if (node_rd.left != '0 || node_rd.right != '0) begin
          cur_d   = child_q;
          cache_d = node_rd;
          state_d = ST_IDLE;
        end else begin
          sym_d    = node_rd.symbol;
          pm_re    = (32'(node_rd.symbol) < PALETTE_SIZE);
          pm_raddr = PW'(node_rd.symbol);
          cur_d    = '0;
          state_d  = ST_DEC_PAL;
        end
      end
      ST_DEC_PAL: begin
        if (out_free) begin
          res_set           = 1'b1;
          res_d.pixel_value = pix_val;
          res_d.color_index = sym_q;
          res_d.column      = col_q;
          res_d.row         = row_q;
          res_d.error_code  = ERR_NONE;
          adv               = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_DEC_ERR: begin
        if (out_free) begin
          res_set          = 1'b1;
          res_d.column     = col_q;
          res_d.row        = row_q;
          res_d.error_code = ERR_NO_CHILD;
          state_d          = ST_IDLE;
        end
      end
      ST_INS_WALK: begin
        if (slot != '0) begin
          nm_re      = 1'b1;
          nm_raddr   = slot;
          ins_node_d = slot;
          state_d    = ST_INS_READ;
        end else if (nodes_used_q == UW'(TREE_NODES)) begin
          if (out_free) begin
            res_set          = 1'b1;
            res_d.column     = col_q;
            res_d.row        = row_q;
            res_d.error_code = ERR_TREE_FULL;
            state_d          = ST_IDLE;
          end
        end else begin
          if (ins_node_q == '0) begin
            root_l_d = upd_ent.left;
            root_r_d = upd_ent.right;
          end else begin
            nm_we    = 1'b1;
            nm_waddr = ins_node_q;
            nm_wdata = upd_ent;
          end
          if (ins_node_q == cur_q && cur_q != '0) begin
            cache_d = upd_ent;
          end
          nodes_used_d = nodes_used_q + 1'b1;
          ins_node_d   = nodes_used_q[NW-1:0];
          ent_d        = '0;
          state_d      = ST_INS_NEW;
        end
      end
      ST_INS_NEW: begin
        nm_we    = 1'b1;
        nm_waddr = ins_node_q;
        nm_wdata = node_t'{left: '0, right: '0, symbol: (pos_q == '0) ? sym_q : '0};
        if (pos_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          pos_d   = pos_q - 1'b1;
          state_d = ST_INS_WALK;
        end
      end
      ST_INS_READ: begin
        ent_d = node_rd;
        if (pos_q == '0) begin
          state_d = ST_INS_SYM;
        end else begin
          pos_d   = pos_q - 1'b1;
          state_d = ST_INS_WALK;
        end
      end
      ST_INS_SYM: begin
        nm_we    = 1'b1;
        nm_waddr = ins_node_q;
        nm_wdata = node_t'{left: ent_q.left, right: ent_q.right, symbol: sym_q};
        state_d  = ST_IDLE;
      end
      ST_PAL_READ: begin
        pm_we    = 1'b1;
        pm_waddr = pal_idx_q;
        if (pal_grey_q) begin
          pm_wdata = {pal_val_q[GREY_W-1:0], pm_rdata[PIX_W-1:0]};
        end else begin
          pm_wdata = {pm_rdata[PAL_W-1:PIX_W], pal_val_q};
        end
        state_d  = ST_PAL_IDLE;
      end
      ST_PAL_IDLE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (image_width_q == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = image_width_q;
    end
    col_inc = {1'b0, col_q} + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (adv) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        if (row_q != ROW_MAX) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
      color_mode_q  <= MODE_GREY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: image_width_q <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_COLOR_MODE:  color_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        default:         image_width_q <= image_width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_l_q     <= '0;
      root_r_q     <= '0;
      cur_q        <= '0;
      nodes_used_q <= UW'(1);
      col_q        <= '0;
      row_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      root_l_q     <= root_l_d;
      root_r_q     <= root_r_d;
      cur_q        <= cur_d;
      nodes_used_q <= nodes_used_d;
      col_q        <= col_d;
      row_q        <= row_d;
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cache_q    <= cache_d;
    child_q    <= child_d;
    ins_node_q <= ins_node_d;
    ent_q      <= ent_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    sym_q      <= sym_d;
    pal_grey_q <= pal_grey_d;
    pal_idx_q  <= pal_idx_d;
    pal_val_q  <= pal_val_d;
    if (res_set) begin
      res_q <= res_d;
    end
  end

endmodule

[sv/pcd_checker.sv]
// Port-level checker for the decoder, bound to the top level.
module pcd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     item_valid_i,
  input logic                     item_ready_i,
  input logic [pcd_pkg::OP_W-1:0] item_op_i,
  input logic                     res_valid_i,
  input logic                     res_ready_i,
  input pcd_pkg::result_t         res_data_i
);
  import pcd_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("stalled result item changed");

  a_err_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.error_code != ERR_NONE
      |-> res_data_i.pixel_value == '0 && res_data_i.color_index == '0)
    else $error("error result carries pixel data");

  a_bit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i && item_op_i == OP_CODE_BIT |=> !item_ready_i)
    else $error("code bit item did not wait for the node read");

endmodule

bind prefix_code_tree_pixel_decoder_core pcd_checker u_pcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .item_op_i    (item_i.data.op),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_data_i   (result_o.data)
);
